// File: rtl/chull_pkg.sv
// Shared constants for the convex hull block.
package chull_pkg;

  localparam int COUNT_W = 7;
  localparam int AREA_W = 62;
  localparam logic [AREA_W-1:0] AREA_MAX = '1;
  localparam int QUEUE_DEPTH = 4;

endpackage

// File: rtl/chull_fifo.sv
// Small first-in first-out queue between the point intake and the hull engine.
module chull_fifo #(
  parameter int W     = 64,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_i,
  output logic [W-1:0] pop_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem_q [DEPTH];
  logic [AW:0]  wptr_q, wptr_d;
  logic [AW:0]  rptr_q, rptr_d;
  logic         full, empty;

  assign empty        = (wptr_q == rptr_q);
  assign full         = (wptr_q[AW] != rptr_q[AW]) && (wptr_q[AW-1:0] == rptr_q[AW-1:0]);
  assign push_ready_o = !full;
  assign pop_valid_o  = !empty;
  assign pop_data_o   = mem_q[rptr_q[AW-1:0]];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push_i && !full) begin
      wptr_d = wptr_q + (AW+1)'(1);
    end
    if (pop_i && !empty) begin
      rptr_d = rptr_q + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full) begin
      mem_q[wptr_q[AW-1:0]] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

endmodule

// File: rtl/chull_front.sv
// Point intake: assigns store slots, flags overflow points as not stored, marks set ends.
module chull_front #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 30
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [COORD_BITS-1:0]           point_x_i,
  input  logic signed [COORD_BITS-1:0]           point_y_i,
  input  logic                                   final_point_i,
  output logic                                   push_o,
  input  logic                                   push_ready_i,
  output logic signed [COORD_BITS-1:0]           item_x_o,
  output logic signed [COORD_BITS-1:0]           item_y_o,
  output logic [$clog2(MAX_POINTS)-1:0]          item_idx_o,
  output logic                                   item_store_o,
  output logic                                   item_final_o
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          store;

  assign store        = (cnt_q < CW'(MAX_POINTS));
  assign in_ready_o   = push_ready_i;
  assign push_o       = in_valid_i;
  assign item_x_o     = point_x_i;
  assign item_y_o     = point_y_i;
  assign item_idx_o   = cnt_q[IW-1:0];
  assign item_store_o = store;
  assign item_final_o = final_point_i;

  // Count points of the current set; a final point closes the set.
  always_comb begin
    cnt_d = cnt_q;
    if (in_valid_i && push_ready_i) begin
      if (final_point_i) begin
        cnt_d = '0;
      end else if (store) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/chull_cross.sv
// Shared cross product unit: u.x*v.y - u.y*v.x on one multiplier, through phases MUL1, MUL2 and SUB.
module chull_cross #(
  parameter int DW = 31
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [DW-1:0]   ux_i,
  input  logic signed [DW-1:0]   uy_i,
  input  logic signed [DW-1:0]   vx_i,
  input  logic signed [DW-1:0]   vy_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic signed [2*DW:0]   res_o
);

  localparam int PW = 2 * DW;
  localparam int RW = 2 * DW + 1;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL1 = 2'd1;
  localparam logic [1:0] PH_MUL2 = 2'd2;
  localparam logic [1:0] PH_SUB  = 2'd3;

  logic [1:0]           phase_q, phase_d;
  logic                 done_q, done_d;
  logic signed [DW-1:0] ux_q, uy_q, vx_q, vy_q;
  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [RW-1:0] res_q;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  assign mul_a  = (phase_q == PH_MUL1) ? ux_q : uy_q;
  assign mul_b  = (phase_q == PH_MUL1) ? vy_q : vx_q;
  assign prod   = PW'(mul_a) * PW'(mul_b);
  assign busy_o = (phase_q != PH_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    unique case (phase_q)
      PH_IDLE: if (start_i) phase_d = PH_MUL1;
      PH_MUL1: phase_d = PH_MUL2;
      PH_MUL2: phase_d = PH_SUB;
      PH_SUB: begin
        phase_d = PH_IDLE;
        done_d  = 1'b1;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == PH_IDLE && start_i) begin
      ux_q <= ux_i;
      uy_q <= uy_i;
      vx_q <= vx_i;
      vy_q <= vy_i;
    end
    if (phase_q == PH_MUL1) p1_q <= prod;
    if (phase_q == PH_MUL2) p2_q <= prod;
    if (phase_q == PH_SUB)  res_q <= RW'(p1_q) - RW'(p2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  a_done_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 4))
    else $error("cross result without matching start");

endmodule

// File: rtl/chull_back.sv
// Hull engine: point store, angular insertion sort, stack scan, area and vertex output.
module chull_back #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 30
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   q_valid_i,
  output logic                                   q_ready_o,
  input  logic signed [COORD_BITS-1:0]           q_x_i,
  input  logic signed [COORD_BITS-1:0]           q_y_i,
  input  logic [$clog2(MAX_POINTS)-1:0]          q_idx_i,
  input  logic                                   q_store_i,
  input  logic                                   q_final_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [COORD_BITS-1:0]           vertex_x_o,
  output logic signed [COORD_BITS-1:0]           vertex_y_o,
  output logic [chull_pkg::COUNT_W-1:0]          hull_count_o,
  output logic [chull_pkg::AREA_W-1:0]           twice_area_o,
  output logic                                   last_vertex_o
);

  import chull_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int RW = 2 * DW + 1;

  localparam logic [4:0] S_LOAD      = 5'd0;
  localparam logic [4:0] S_SORT_I    = 5'd1;
  localparam logic [4:0] S_SORT_K    = 5'd2;
  localparam logic [4:0] S_SORT_J    = 5'd3;
  localparam logic [4:0] S_SORT_B    = 5'd4;
  localparam logic [4:0] S_SORT_W    = 5'd5;
  localparam logic [4:0] S_SCAN_INIT = 5'd6;
  localparam logic [4:0] S_SCAN_I    = 5'd7;
  localparam logic [4:0] S_SCAN_P    = 5'd8;
  localparam logic [4:0] S_SCAN_CHK  = 5'd9;
  localparam logic [4:0] S_SCAN_HT   = 5'd10;
  localparam logic [4:0] S_SCAN_T    = 5'd11;
  localparam logic [4:0] S_SCAN_S    = 5'd12;
  localparam logic [4:0] S_SCAN_W    = 5'd13;
  localparam logic [4:0] S_AREA_INIT = 5'd14;
  localparam logic [4:0] S_AREA_O    = 5'd15;
  localparam logic [4:0] S_AREA_K    = 5'd16;
  localparam logic [4:0] S_AREA_HA   = 5'd17;
  localparam logic [4:0] S_AREA_A    = 5'd18;
  localparam logic [4:0] S_AREA_B    = 5'd19;
  localparam logic [4:0] S_AREA_W    = 5'd20;
  localparam logic [4:0] S_EMIT_H    = 5'd21;
  localparam logic [4:0] S_EMIT_P    = 5'd22;
  localparam logic [4:0] S_EMIT_D    = 5'd23;

  // Memories
  logic signed [CB-1:0] memx [MAX_POINTS];
  logic signed [CB-1:0] memy [MAX_POINTS];
  logic [IW-1:0]        hmem [MAX_POINTS];
  logic signed [CB-1:0] rdx_q, rdy_q;
  logic [IW-1:0]        hrd_q;

  logic                 p_we, h_we;
  logic [IW-1:0]        p_waddr, p_raddr, h_waddr, h_raddr, h_wdata;
  logic signed [CB-1:0] p_wx, p_wy;

  // Control and working registers
  logic [4:0]           state_q, state_d;
  logic [CW-1:0]        n_q, n_d, i_q, i_d, j_q, j_d, k_q, k_d, top_q, top_d;
  logic signed [CB-1:0] pivx_q, pivx_d, pivy_q, pivy_d;
  logic signed [CB-1:0] keyx_q, keyx_d, keyy_q, keyy_d;
  logic signed [CB-1:0] bx_q, bx_d, by_q, by_d;
  logic signed [CB-1:0] px_q, px_d, py_q, py_d;
  logic signed [CB-1:0] tx_q, tx_d, ty_q, ty_d;
  logic signed [CB-1:0] ox_q, ox_d, oy_q, oy_d;
  logic signed [CB-1:0] ax_q, ax_d, ay_q, ay_d;
  logic [AREA_W-1:0]    area_q, area_d;

  logic                 ov_q, ov_d;
  logic signed [CB-1:0] ox_out_q, ox_out_d, oy_out_q, oy_out_d;
  logic [COUNT_W-1:0]   ocnt_q, ocnt_d;
  logic [AREA_W-1:0]    oarea_q, oarea_d;
  logic                 olast_q, olast_d;

  // Cross unit hookup
  logic                 cr_start, cr_busy, cr_done;
  logic signed [DW-1:0] cr_ux, cr_uy, cr_vx, cr_vy;
  logic signed [RW-1:0] cr_res;

  // Helpers
  logic [CW-1:0]        jm1, topm1, topm2, kp1, ip1;
  logic [IW-1:0]        emit_h;
  logic                 pivot_lt;
  logic signed [DW-1:0] tax, tbx, tay, tby;
  logic [DW-1:0]        tay_m, tby_m, tax_m, tbx_m;
  logic                 tie_less, sort_less;
  logic [RW-1:0]        cr_mag;
  logic [AREA_W+1:0]    area_sum;
  logic [AREA_W-1:0]    area_sat;

  chull_cross #(.DW(DW)) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cr_start),
    .ux_i    (cr_ux),
    .uy_i    (cr_uy),
    .vx_i    (cr_vx),
    .vy_i    (cr_vy),
    .busy_o  (cr_busy),
    .done_o  (cr_done),
    .res_o   (cr_res)
  );

  assign jm1    = j_q - CW'(1);
  assign topm1  = top_q - CW'(1);
  assign topm2  = top_q - CW'(2);
  assign kp1    = k_q + CW'(1);
  assign ip1    = i_q + CW'(1);
  assign emit_h = (k_q == '0) ? '0 : IW'(top_q - k_q);

  assign pivot_lt = (q_x_i < pivx_q) || ((q_x_i == pivx_q) && (q_y_i < pivy_q));

  // Collinear tie: nearer point first, all points lie on one side of the pivot
  assign tax      = DW'(keyx_q) - DW'(pivx_q);
  assign tay      = DW'(keyy_q) - DW'(pivy_q);
  assign tbx      = DW'(bx_q) - DW'(pivx_q);
  assign tby      = DW'(by_q) - DW'(pivy_q);
  assign tax_m    = tax[DW-1] ? DW'(-tax) : DW'(tax);
  assign tbx_m    = tbx[DW-1] ? DW'(-tbx) : DW'(tbx);
  assign tay_m    = tay[DW-1] ? DW'(-tay) : DW'(tay);
  assign tby_m    = tby[DW-1] ? DW'(-tby) : DW'(tby);
  assign tie_less = (tax_m < tbx_m) || ((tax_m == tbx_m) && (tay_m < tby_m));
  assign sort_less = (cr_res != 0) ? (cr_res > 0) : tie_less;

  assign cr_mag   = cr_res[RW-1] ? RW'(-cr_res) : RW'(cr_res);
  assign area_sum = (AREA_W+2)'(area_q) + (AREA_W+2)'(cr_mag);
  assign area_sat = (area_sum > (AREA_W+2)'(AREA_MAX)) ? AREA_MAX : area_sum[AREA_W-1:0];

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    top_d    = top_q;
    pivx_d   = pivx_q;
    pivy_d   = pivy_q;
    keyx_d   = keyx_q;
    keyy_d   = keyy_q;
    bx_d     = bx_q;
    by_d     = by_q;
    px_d     = px_q;
    py_d     = py_q;
    tx_d     = tx_q;
    ty_d     = ty_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    ax_d     = ax_q;
    ay_d     = ay_q;
    area_d   = area_q;
    ov_d     = ov_q;
    ox_out_d = ox_out_q;
    oy_out_d = oy_out_q;
    ocnt_d   = ocnt_q;
    oarea_d  = oarea_q;
    olast_d  = olast_q;
    q_ready_o = 1'b0;
    p_we     = 1'b0;
    p_waddr  = '0;
    p_wx     = keyx_q;
    p_wy     = keyy_q;
    p_raddr  = '0;
    h_we     = 1'b0;
    h_waddr  = top_q[IW-1:0];
    h_wdata  = i_q[IW-1:0];
    h_raddr  = '0;
    cr_start = 1'b0;
    cr_ux    = '0;
    cr_uy    = '0;
    cr_vx    = '0;
    cr_vy    = '0;

    // Drop the held vertex once taken
    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          if (q_store_i) begin
            p_we    = 1'b1;
            p_waddr = q_idx_i;
            p_wx    = q_x_i;
            p_wy    = q_y_i;
            n_d     = CW'(q_idx_i) + CW'(1);
            if (q_idx_i == '0 || pivot_lt) begin
              pivx_d = q_x_i;
              pivy_d = q_y_i;
            end
          end
          if (q_final_i) begin
            i_d     = CW'(1);
            state_d = S_SORT_I;
          end
        end
      end
      S_SORT_I: begin
        if (i_q >= n_q) begin
          state_d = S_SCAN_INIT;
        end else begin
          p_raddr = i_q[IW-1:0];
          state_d = S_SORT_K;
        end
      end
      S_SORT_K: begin
        keyx_d  = rdx_q;
        keyy_d  = rdy_q;
        j_d     = i_q;
        state_d = S_SORT_J;
      end
      S_SORT_J: begin
        if (j_q == '0) begin
          p_we    = 1'b1;
          p_waddr = '0;
          i_d     = ip1;
          state_d = S_SORT_I;
        end else begin
          p_raddr = jm1[IW-1:0];
          state_d = S_SORT_B;
        end
      end
      S_SORT_B: begin
        bx_d     = rdx_q;
        by_d     = rdy_q;
        cr_start = 1'b1;
        cr_ux    = DW'(keyx_q) - DW'(pivx_q);
        cr_uy    = DW'(keyy_q) - DW'(pivy_q);
        cr_vx    = DW'(rdx_q) - DW'(pivx_q);
        cr_vy    = DW'(rdy_q) - DW'(pivy_q);
        state_d  = S_SORT_W;
      end
      S_SORT_W: begin
        if (cr_done) begin
          p_we    = 1'b1;
          p_waddr = j_q[IW-1:0];
          if (sort_less) begin
            // Shift the stored point up one slot
            p_wx    = bx_q;
            p_wy    = by_q;
            j_d     = jm1;
            state_d = S_SORT_J;
          end else begin
            i_d     = ip1;
            state_d = S_SORT_I;
          end
        end
      end
      S_SCAN_INIT: begin
        h_we    = 1'b1;
        h_waddr = '0;
        h_wdata = '0;
        top_d   = CW'(1);
        i_d     = CW'(1);
        state_d = S_SCAN_I;
      end
      S_SCAN_I: begin
        if (i_q >= n_q) begin
          state_d = S_AREA_INIT;
        end else begin
          p_raddr = i_q[IW-1:0];
          state_d = S_SCAN_P;
        end
      end
      S_SCAN_P: begin
        px_d    = rdx_q;
        py_d    = rdy_q;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (top_q > CW'(1)) begin
          h_raddr = topm1[IW-1:0];
          state_d = S_SCAN_HT;
        end else begin
          h_we    = 1'b1;
          top_d   = top_q + CW'(1);
          i_d     = ip1;
          state_d = S_SCAN_I;
        end
      end
      S_SCAN_HT: begin
        p_raddr = hrd_q;
        h_raddr = topm2[IW-1:0];
        state_d = S_SCAN_T;
      end
      S_SCAN_T: begin
        tx_d    = rdx_q;
        ty_d    = rdy_q;
        p_raddr = hrd_q;
        state_d = S_SCAN_S;
      end
      S_SCAN_S: begin
        cr_start = 1'b1;
        cr_ux    = DW'(tx_q) - DW'(rdx_q);
        cr_uy    = DW'(ty_q) - DW'(rdy_q);
        cr_vx    = DW'(px_q) - DW'(tx_q);
        cr_vy    = DW'(py_q) - DW'(ty_q);
        state_d  = S_SCAN_W;
      end
      S_SCAN_W: begin
        if (cr_done) begin
          if (cr_res <= 0) begin
            // Not a strict left turn: pop
            top_d   = topm1;
            state_d = S_SCAN_CHK;
          end else begin
            h_we    = 1'b1;
            top_d   = top_q + CW'(1);
            i_d     = ip1;
            state_d = S_SCAN_I;
          end
        end
      end
      S_AREA_INIT: begin
        area_d  = '0;
        k_d     = CW'(1);
        p_raddr = '0;
        state_d = S_AREA_O;
      end
      S_AREA_O: begin
        ox_d    = rdx_q;
        oy_d    = rdy_q;
        state_d = S_AREA_K;
      end
      S_AREA_K: begin
        if (kp1 >= top_q) begin
          k_d     = '0;
          state_d = S_EMIT_H;
        end else begin
          h_raddr = k_q[IW-1:0];
          state_d = S_AREA_HA;
        end
      end
      S_AREA_HA: begin
        p_raddr = hrd_q;
        h_raddr = kp1[IW-1:0];
        state_d = S_AREA_A;
      end
      S_AREA_A: begin
        ax_d    = rdx_q;
        ay_d    = rdy_q;
        p_raddr = hrd_q;
        state_d = S_AREA_B;
      end
      S_AREA_B: begin
        cr_start = 1'b1;
        cr_ux    = DW'(ax_q) - DW'(ox_q);
        cr_uy    = DW'(ay_q) - DW'(oy_q);
        cr_vx    = DW'(rdx_q) - DW'(ox_q);
        cr_vy    = DW'(rdy_q) - DW'(oy_q);
        state_d  = S_AREA_W;
      end
      S_AREA_W: begin
        if (cr_done) begin
          area_d  = area_sat;
          k_d     = kp1;
          state_d = S_AREA_K;
        end
      end
      S_EMIT_H: begin
        h_raddr = emit_h;
        state_d = S_EMIT_P;
      end
      S_EMIT_P: begin
        h_raddr = emit_h;
        p_raddr = hrd_q;
        state_d = S_EMIT_D;
      end
      S_EMIT_D: begin
        h_raddr = emit_h;
        p_raddr = hrd_q;
        if (!ov_q || out_ready_i) begin
          ov_d     = 1'b1;
          ox_out_d = rdx_q;
          oy_out_d = rdy_q;
          ocnt_d   = COUNT_W'(top_q);
          oarea_d  = area_q;
          olast_d  = (kp1 == top_q);
          k_d      = kp1;
          state_d  = (kp1 == top_q) ? S_LOAD : S_EMIT_H;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      memx[p_waddr] <= p_wx;
      memy[p_waddr] <= p_wy;
    end
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    rdx_q <= memx[p_raddr];
    rdy_q <= memy[p_raddr];
    hrd_q <= hmem[h_raddr];
  end

  always_ff @(posedge clk_i) begin
    keyx_q   <= keyx_d;
    keyy_q   <= keyy_d;
    bx_q     <= bx_d;
    by_q     <= by_d;
    px_q     <= px_d;
    py_q     <= py_d;
    tx_q     <= tx_d;
    ty_q     <= ty_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    ox_out_q <= ox_out_d;
    oy_out_q <= oy_out_d;
    ocnt_q   <= ocnt_d;
    oarea_q  <= oarea_d;
    olast_q  <= olast_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      top_q   <= '0;
      pivx_q  <= '0;
      pivy_q  <= '0;
      area_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      top_q   <= top_d;
      pivx_q  <= pivx_d;
      pivy_q  <= pivy_d;
      area_q  <= area_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign vertex_x_o    = ox_out_q;
  assign vertex_y_o    = oy_out_q;
  assign hull_count_o  = ocnt_q;
  assign twice_area_o  = oarea_q;
  assign last_vertex_o = olast_q;

  a_stack_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_CHK) |-> (top_q != '0 && top_q <= n_q))
    else $error("hull stack depth outside point count");

  a_cross_idle_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> !cr_busy)
    else $error("cross unit busy while loading points");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (ocnt_q != '0))
    else $error("vertex shown with zero hull count");

endmodule

// File: rtl/convex_hull_with_area.sv
// Top level of the convex hull block: intake, queue and hull engine.
//
// Points stream in one transaction per point until one with final_point_i set;
// the block then finds the leftmost (lowest on ties) pivot, sorts the stored points by
// angle around it (nearer first on ties) with an insertion sort, runs a Graham
// stack scan that drops collinear points, and sums twice the fan area from the
// pivot, saturating at 2^62-1. Vertices leave one transaction each: pivot first,
// then the stack from the top down, each tagged with the vertex count, the area
// and a last flag. Up to MAX_POINTS points are kept per set; further points are
// ignored, though a final flag on one still closes the set. Points are taken at
// one per cycle into a four-entry queue while it has room, and written to the
// point memory at one per cycle while the engine is loading. Once the final point
// arrives, the engine sorts (worst case N*(N-1)/2 shifts), scans, sums the area
// and emits the vertices, each vertex waiting while the receiver stalls. The pace
// is set by the single cross product unit (one multiplier) and the single read
// port of the point memory. The queue keeps taking points during a run until it
// fills. No clearing pass follows reset.
module convex_hull_with_area #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 30
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [COORD_BITS-1:0]           point_x_i,
  input  logic signed [COORD_BITS-1:0]           point_y_i,
  input  logic                                   final_point_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [COORD_BITS-1:0]           vertex_x_o,
  output logic signed [COORD_BITS-1:0]           vertex_y_o,
  output logic [chull_pkg::COUNT_W-1:0]          hull_count_o,
  output logic [chull_pkg::AREA_W-1:0]           twice_area_o,
  output logic                                   last_vertex_o
);

  import chull_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int QW = 2 + IW + 2 * COORD_BITS;

  logic                         push, push_ready;
  logic signed [COORD_BITS-1:0] item_x, item_y;
  logic [IW-1:0]                item_idx;
  logic                         item_store, item_final;
  logic [QW-1:0]                push_data, pop_data;
  logic                         pop_valid, pop_ready;

  // Intake: classify each point transaction as stored or dropped
  chull_front #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .final_point_i (final_point_i),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .item_x_o      (item_x),
    .item_y_o      (item_y),
    .item_idx_o    (item_idx),
    .item_store_o  (item_store),
    .item_final_o  (item_final)
  );

  assign push_data = {item_store, item_final, item_idx, item_x, item_y};

  // Queue decouples intake from the hull engine
  chull_fifo #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Hull engine: sort, scan, area and vertex output
  chull_back #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (pop_valid),
    .q_ready_o     (pop_ready),
    .q_x_i         (pop_data[2*COORD_BITS-1:COORD_BITS]),
    .q_y_i         (pop_data[COORD_BITS-1:0]),
    .q_idx_i       (pop_data[2*COORD_BITS+IW-1:2*COORD_BITS]),
    .q_store_i     (pop_data[QW-1]),
    .q_final_i     (pop_data[QW-2]),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .vertex_x_o    (vertex_x_o),
    .vertex_y_o    (vertex_y_o),
    .hull_count_o  (hull_count_o),
    .twice_area_o  (twice_area_o),
    .last_vertex_o (last_vertex_o)
  );

endmodule

// File: verif/hull_checker.sv
// Checker for the convex hull block: predicts hull vertices and compares them.
module hull_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [29:0]                  point_x_i,
  input  logic signed [29:0]                  point_y_i,
  input  logic                                final_point_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [29:0]                  vertex_x_i,
  input  logic signed [29:0]                  vertex_y_i,
  input  logic [chull_pkg::COUNT_W-1:0]       hull_count_i,
  input  logic [chull_pkg::AREA_W-1:0]        twice_area_i,
  input  logic                                last_vertex_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);

  localparam int SetMax = 64;

  typedef struct {
    longint x;
    longint y;
  } point_t;

  typedef struct {
    logic [29:0]                   vx;
    logic [29:0]                   vy;
    logic [chull_pkg::COUNT_W-1:0] count;
    logic [chull_pkg::AREA_W-1:0]  area;
    logic                          last;
  } vertex_t;

  point_t  set_pts[SetMax];
  int      set_size;
  point_t  pivot;
  vertex_t vertex_q[$];
  int      fails;

  assign fail_count_o = fails;
  assign pending_o    = vertex_q.size();

  function automatic longint cross_of(point_t o, point_t a, point_t b);
    return (a.x - o.x) * (b.y - o.y) - (a.y - o.y) * (b.x - o.x);
  endfunction

  // Angle order around the pivot; nearer first on collinear ties.
  function automatic bit angle_before(point_t a, point_t b);
    longint c;
    longint da;
    longint db;
    c = cross_of(pivot, a, b);
    if (c != 0) return c > 0;
    da = (a.x - pivot.x) * (a.x - pivot.x) + (a.y - pivot.y) * (a.y - pivot.y);
    db = (b.x - pivot.x) * (b.x - pivot.x) + (b.y - pivot.y) * (b.y - pivot.y);
    return da < db;
  endfunction

  task automatic predict_hull();
    int                 stack[SetMax];
    int                 depth;
    int                 j;
    int                 idx;
    point_t             key;
    point_t             s;
    point_t             t;
    point_t             p;
    longint             c;
    longint unsigned    m;
    longint unsigned    area;
    vertex_t            v;
    pivot = set_pts[0];
    for (int i = 1; i < set_size; i++) begin
      p = set_pts[i];
      if (p.x < pivot.x || (p.x == pivot.x && p.y < pivot.y)) pivot = p;
    end
    for (int i = 1; i < set_size; i++) begin
      key = set_pts[i];
      j = i;
      while (j > 0 && angle_before(key, set_pts[j-1])) begin
        set_pts[j] = set_pts[j-1];
        j--;
      end
      set_pts[j] = key;
    end
    stack[0] = 0;
    depth = 1;
    for (int i = 1; i < set_size; i++) begin
      while (depth > 1) begin
        t = set_pts[stack[depth-1]];
        s = set_pts[stack[depth-2]];
        p = set_pts[i];
        c = (t.x - s.x) * (p.y - t.y) - (t.y - s.y) * (p.x - t.x);
        if (c <= 0) depth--;
        else break;
      end
      stack[depth] = i;
      depth++;
    end
    area = 0;
    for (int i = 1; i + 1 < depth; i++) begin
      c = cross_of(set_pts[stack[0]], set_pts[stack[i]], set_pts[stack[i+1]]);
      m = (c < 0) ? longint'(-c) : c;
      if (m > longint'(chull_pkg::AREA_MAX) - area) area = chull_pkg::AREA_MAX;
      else area += m;
    end
    for (int k = 0; k < depth; k++) begin
      idx = (k == 0) ? stack[0] : stack[depth-k];
      v.vx    = set_pts[idx].x[29:0];
      v.vy    = set_pts[idx].y[29:0];
      v.count = depth[chull_pkg::COUNT_W-1:0];
      v.area  = area[chull_pkg::AREA_W-1:0];
      v.last  = (k + 1 == depth);
      vertex_q.insert(vertex_q.size(), v);
    end
    set_size = 0;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    fails++;
    if (fails <= 40) $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
  endtask

  initial begin
    fails = 0;
    set_size = 0;
  end

  always @(posedge clk_i) begin
    vertex_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        if (set_size < SetMax) begin
          set_pts[set_size].x = longint'(point_x_i);
          set_pts[set_size].y = longint'(point_y_i);
          set_size++;
        end
        if (final_point_i) predict_hull();
      end
      if (out_valid_i && out_ready_i) begin
        if (vertex_q.size() == 0) begin
          report_mismatch("unexpected vertex x", 64'(vertex_x_i), '0);
        end else begin
          w = vertex_q.pop_front();
          if (vertex_x_i !== w.vx)
            report_mismatch("vertex_x", 64'(vertex_x_i), 64'(w.vx));
          if (vertex_y_i !== w.vy)
            report_mismatch("vertex_y", 64'(vertex_y_i), 64'(w.vy));
          if (hull_count_i !== w.count)
            report_mismatch("hull_count", 64'(hull_count_i), 64'(w.count));
          if (twice_area_i !== w.area)
            report_mismatch("twice_area", 64'(twice_area_i), 64'(w.area));
          if (last_vertex_i !== w.last)
            report_mismatch("last_vertex", 64'(last_vertex_i), 64'(w.last));
        end
      end
    end
  end

  // Leftover expectations are flagged by the top through pending_o.

endmodule

// File: verif/tb_convex_hull_with_area.sv
// Testbench top for the convex hull block: stimulus, pacing and verdict.
module tb_convex_hull_with_area;

  localparam logic signed [29:0] CoordMin = -30'sd536870912;
  localparam logic signed [29:0] CoordMax = 30'sd536870911;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic signed [29:0]              point_x = '0;
  logic signed [29:0]              point_y = '0;
  logic                            final_point = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic signed [29:0]              vertex_x;
  logic signed [29:0]              vertex_y;
  logic [chull_pkg::COUNT_W-1:0]   hull_count;
  logic [chull_pkg::AREA_W-1:0]    twice_area;
  logic                            last_vertex;
  int                              fail_count;
  int                              pending;

  // Pacing knobs, percent of cycles.
  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_go   = 1'b0;
  bit hold_on   = 1'b0;

  always #4 clk_i = ~clk_i;

  convex_hull_with_area i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .final_point_i (final_point),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .vertex_x_o    (vertex_x),
    .vertex_y_o    (vertex_y),
    .hull_count_o  (hull_count),
    .twice_area_o  (twice_area),
    .last_vertex_o (last_vertex)
  );

  hull_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .final_point_i (final_point),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .vertex_x_i    (vertex_x),
    .vertex_y_i    (vertex_y),
    .hull_count_i  (hull_count),
    .twice_area_i  (twice_area),
    .last_vertex_i (last_vertex),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Receiver: stall at random, or hold off entirely during a long hold.
  always @(posedge clk_i) begin
    out_ready <= hold_on ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // Long hold-off, counted here so the sender keeps offering points meanwhile.
  initial begin
    forever begin
      wait (hold_go);
      @(posedge clk_i);
      hold_on <= 1'b1;
      repeat (2000) @(posedge clk_i);
      hold_on <= 1'b0;
      wait (!hold_go);
    end
  end

  // Offer one point; hold valid and payload until the transaction completes.
  task automatic send_point(logic signed [29:0] x, logic signed [29:0] y, logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    point_x     <= x;
    point_y     <= y;
    final_point <= fin;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Pick a coordinate: full range, a tiny grid for ties and collinear runs, or extremes.
  function automatic logic signed [29:0] pick_coord(int mode);
    case (mode)
      0: pick_coord = 30'($urandom());
      1: pick_coord = 30'($signed($urandom_range(6)) - 3);
      default: begin
        case ($urandom_range(2))
          0: pick_coord = CoordMin;
          1: pick_coord = CoordMax;
          default: pick_coord = '0;
        endcase
      end
    endcase
  endfunction

  task automatic send_set(int n, int mode);
    for (int i = 0; i < n; i++) begin
      send_point(pick_coord(mode), pick_coord(mode), i == n - 1);
    end
  endtask

  // Drop valid and wait until every expected vertex has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  initial begin
    int sent;
    int n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single point, coincident pair, extreme diagonal pair.
    send_point(0, 0, 1'b1);
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b1);
    send_point(CoordMin, CoordMin, 1'b0);
    send_point(CoordMax, CoordMax, 1'b1);
    // All collinear: only the two ends survive.
    send_point(0, 0, 1'b0);
    send_point(1, 1, 1'b0);
    send_point(2, 2, 1'b0);
    send_point(3, 3, 1'b1);
    // Extreme triangle for the largest areas.
    send_point(CoordMax, CoordMin, 1'b0);
    send_point(CoordMin, CoordMin, 1'b0);
    send_point(CoordMin, CoordMax, 1'b1);
    // Square with an interior point and a point on an edge.
    send_point(4, 4, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(2, 2, 1'b0);
    send_point(2, 0, 1'b0);
    send_point(4, 0, 1'b0);
    send_point(0, 4, 1'b1);
    drain();

    // Random phases: no idling, sender idle, receiver stall, both.
    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 60 : (phase == 3) ? 33 : 0;
      stall_pct = (phase == 2) ? 60 : (phase == 3) ? 33 : 0;
      if (phase == 2) begin
        // Fill the block while the receiver holds off.
        hold_go = 1'b1;
        send_set(10, 0);
        send_set(6, 1);
        hold_go = 1'b0;
        sent += 16;
      end
      if (phase == 3) begin
        // Overflow: points past the store size are dropped, the final still closes.
        send_set(66, 1);
        sent += 66;
      end
      while (sent < (phase + 1) * 15) begin
        n = $urandom_range(1, 10);
        send_set(n, $urandom_range(99) < 45 ? 0 : ($urandom_range(99) < 75 ? 1 : 2));
        sent += n;
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
